/* src/field_separator_detector_macros.svh */
// Assertion macros used by field_separator_detector.sv.
`ifndef FIELD_SEPARATOR_DETECTOR_MACROS_SVH
`define FIELD_SEPARATOR_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define FSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/fsd_pkg.sv */
`default_nettype none

package fsd_pkg;

	// Fixed field widths
	localparam int FSD_LEN_W      = 25;
	localparam int FSD_ROWS_W     = 8;
	localparam int FSD_CFG_IDX_W  = 8;
	localparam int FSD_CFG_DATA_W = 32;

	// Defaults for the top-level parameters
	localparam int FSD_NUM_SEP = 4;
	localparam int FSD_COUNT_W = 25;

	// Register reset values
	localparam logic [FSD_LEN_W-1:0]  FSD_MAX_LEN_RST = 25'd16777216;
	localparam logic [FSD_ROWS_W-1:0] FSD_ROWS_RST    = 8'd10;

	// Register indexes
	localparam logic [FSD_CFG_IDX_W-1:0] REG_MAX_LINE_LEN  = 8'd0;
	localparam logic [FSD_CFG_IDX_W-1:0] REG_ROWS_TO_CHECK = 8'd1;

	// Item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	// Line terminators
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_ROW    = 2'd1,
		PH_CHECK  = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OUT_FOUND   = 2'd0,
		OUT_NO_LINE = 2'd1,
		OUT_NO_SEP  = 2'd2,
		OUT_AMBIG   = 2'd3
	} outcome_t;

	// Separator character for each slot; slots past the fourth are NUL
	function automatic logic [7:0] fsd_sep_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h2C;  // comma
			3'd1:    c = 8'h09;  // tab
			3'd2:    c = 8'h20;  // space
			3'd3:    c = 8'h3B;  // semicolon
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* src/fsd_in_if.sv */
`default_nettype none

interface fsd_in_if import fsd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

/* src/fsd_out_if.sv */
`default_nettype none

interface fsd_out_if import fsd_pkg::*; ();
	logic       valid;
	logic       ready;
	outcome_t   outcome;
	logic [7:0] header_sep_char;
	logic [7:0] data_sep_char;

	modport source (output valid, output outcome, output header_sep_char,
		output data_sep_char, input ready);
	modport sink   (input valid, input outcome, input header_sep_char,
		input data_sep_char, output ready);
endinterface

`default_nettype wire

/* src/fsd_cfg_if.sv */
`default_nettype none

interface fsd_cfg_if import fsd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [FSD_CFG_IDX_W-1:0]  reg_index;
	logic [FSD_CFG_DATA_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* src/field_separator_detector.sv */
// field_separator_detector
//
// Channels: stream takes one item per handshake, either a data byte
// (kind 0) or an end-of-stream mark (kind 1). result gives one item per
// end-of-stream mark: outcome plus the chosen header and data separator.
// cfg writes max_line_length (index 0) and rows_to_check (index 1); it is
// always ready and should only be used while no stream item is in flight.
// Throughput: one stream item per cycle while stream is ready. A data byte updates the line
// counters in the cycle it is accepted and gives no result.
// Result: the acceptance of an end-of-stream mark captures the final counts
// in the capture stage; the match is then registered in the output register
// when result can advance. The line state is cleared at the acceptance edge,
// so a new stream may start in the following cycle.
// Stall: if result is stalled, one result waits in the output register and
// one captured end-of-stream may wait behind it; once both are held, stream
// drops ready for every item until result takes the waiting one.
// Reset: arst_n clears all line and count state and loads the register
// defaults (16777216 and 10). Nothing is pending after reset.
`default_nettype none

`include "field_separator_detector_macros.svh"

module field_separator_detector import fsd_pkg::*; #(
	parameter int NUM_SEPARATORS = FSD_NUM_SEP,
	parameter int COUNT_WIDTH    = FSD_COUNT_W
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fsd_in_if.sink     stream,
	fsd_out_if.source  result,
	fsd_cfg_if.sink    cfg
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// Registers
	logic [FSD_LEN_W-1:0]  max_len_q;
	logic [FSD_ROWS_W-1:0] rows_to_check_q;

	// Live line state
	phase_t                 phase_q, phase_d;
	logic                   pending_cr_q, pending_cr_d;
	logic [FSD_LEN_W-1:0]   line_len_q, line_len_d;
	logic [COUNT_WIDTH-1:0] line_cnt_q [NUM_SEPARATORS];
	logic [COUNT_WIDTH-1:0] line_cnt_d [NUM_SEPARATORS];
	logic [COUNT_WIDTH-1:0] hdr_cnt_q  [NUM_SEPARATORS];
	logic [COUNT_WIDTH-1:0] hdr_cnt_d  [NUM_SEPARATORS];
	logic [COUNT_WIDTH-1:0] row_cnt_q  [NUM_SEPARATORS];
	logic [COUNT_WIDTH-1:0] row_cnt_d  [NUM_SEPARATORS];
	logic                   incons_q   [NUM_SEPARATORS];
	logic                   incons_d   [NUM_SEPARATORS];
	logic [FSD_ROWS_W-1:0]  rows_chk_q, rows_chk_d;

	// Line-finish results
	phase_t                 fin_phase;
	logic [COUNT_WIDTH-1:0] fin_hdr [NUM_SEPARATORS];
	logic [COUNT_WIDTH-1:0] fin_row [NUM_SEPARATORS];
	logic                   fin_inc [NUM_SEPARATORS];
	logic [FSD_ROWS_W-1:0]  fin_rc;

	// Capture stage and output register
	logic                   eos_s1;
	phase_t                 phase_s1;
	logic [COUNT_WIDTH-1:0] hdr_s1 [NUM_SEPARATORS];
	logic [COUNT_WIDTH-1:0] row_s1 [NUM_SEPARATORS];
	logic                   inc_s1 [NUM_SEPARATORS];
	logic                   out_valid_q;
	outcome_t               outcome_q;
	logic [7:0]             hsep_q;
	logic [7:0]             dsep_q;
	outcome_t               dec_outcome;
	logic [7:0]             dec_hsep;
	logic [7:0]             dec_dsep;

	logic                 in_fire;
	logic                 advance;
	logic                 is_eos;
	logic [FSD_LEN_W-1:0] limit;
	logic [7:0]           b;
	logic                 cut;
	logic                 is_lf;
	logic                 is_cr;

	assign advance      = !out_valid_q || result.ready;
	assign stream.ready = !eos_s1 || advance;
	assign in_fire      = stream.valid && stream.ready;
	assign is_eos       = (stream.kind == KIND_EOS);
	assign b            = stream.data_byte;
	assign limit        = (max_len_q == '0) ? FSD_LEN_W'(1) : max_len_q;
	assign cut          = (line_len_q >= limit);
	assign is_lf        = (b == CHAR_LF);
	assign is_cr        = (b == CHAR_CR);
	assign cfg.ready    = 1'b1;

	// Effect of ending the current line (no effect when it is empty)
	always_comb begin
		fin_phase = phase_q;
		fin_rc    = rows_chk_q;
		fin_hdr   = hdr_cnt_q;
		fin_row   = row_cnt_q;
		fin_inc   = incons_q;
		if (line_len_q != '0) begin
			case (phase_q)
				PH_HEADER: begin
					fin_hdr   = line_cnt_q;
					fin_phase = PH_ROW;
				end
				PH_ROW: begin
					fin_row   = line_cnt_q;
					fin_rc    = '0;
					fin_phase = (rows_to_check_q != '0) ? PH_CHECK : PH_DONE;
				end
				PH_CHECK: begin
					for (int s = 0; s < NUM_SEPARATORS; s++)
						if (line_cnt_q[s] != row_cnt_q[s])
							fin_inc[s] = 1'b1;
					fin_rc = rows_chk_q + 1'b1;
					if (fin_rc >= rows_to_check_q)
						fin_phase = PH_DONE;
				end
				default: ;
			endcase
		end
	end

	// Next live state for an accepted data byte
	always_comb begin
		phase_d      = phase_q;
		pending_cr_d = pending_cr_q;
		line_len_d   = line_len_q;
		line_cnt_d   = line_cnt_q;
		hdr_cnt_d    = hdr_cnt_q;
		row_cnt_d    = row_cnt_q;
		incons_d     = incons_q;
		rows_chk_d   = rows_chk_q;
		if (phase_q != PH_DONE) begin
			pending_cr_d = 1'b0;
			if (!(pending_cr_q && is_lf)) begin
				if (cut || is_lf || is_cr) begin
					phase_d    = fin_phase;
					hdr_cnt_d  = fin_hdr;
					row_cnt_d  = fin_row;
					incons_d   = fin_inc;
					rows_chk_d = fin_rc;
					line_len_d = '0;
					for (int s = 0; s < NUM_SEPARATORS; s++)
						line_cnt_d[s] = '0;
				end
				if (!(cut && fin_phase == PH_DONE)) begin
					if (is_cr) begin
						pending_cr_d = 1'b1;
					end else if (!is_lf) begin
						line_len_d = (cut ? '0 : line_len_q) + 1'b1;
						for (int s = 0; s < NUM_SEPARATORS; s++) begin
							line_cnt_d[s] = cut ? '0 : line_cnt_q[s];
							if (b == fsd_sep_char(3'(s)) && line_cnt_d[s] != CNT_MAX)
								line_cnt_d[s] = line_cnt_d[s] + 1'b1;
						end
					end
				end
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q       <= FSD_MAX_LEN_RST;
			rows_to_check_q <= FSD_ROWS_RST;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_MAX_LINE_LEN:  max_len_q       <= cfg.wdata[FSD_LEN_W-1:0];
				REG_ROWS_TO_CHECK: rows_to_check_q <= cfg.wdata[FSD_ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// Live line state; an end-of-stream returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			pending_cr_q <= 1'b0;
			line_len_q   <= '0;
			rows_chk_q   <= '0;
			for (int s = 0; s < NUM_SEPARATORS; s++) begin
				line_cnt_q[s] <= '0;
				hdr_cnt_q[s]  <= '0;
				row_cnt_q[s]  <= '0;
				incons_q[s]   <= 1'b0;
			end
		end else if (in_fire) begin
			if (is_eos) begin
				phase_q      <= PH_HEADER;
				pending_cr_q <= 1'b0;
				line_len_q   <= '0;
				rows_chk_q   <= '0;
				for (int s = 0; s < NUM_SEPARATORS; s++) begin
					line_cnt_q[s] <= '0;
					hdr_cnt_q[s]  <= '0;
					row_cnt_q[s]  <= '0;
					incons_q[s]   <= 1'b0;
				end
			end else begin
				phase_q      <= phase_d;
				pending_cr_q <= pending_cr_d;
				line_len_q   <= line_len_d;
				rows_chk_q   <= rows_chk_d;
				line_cnt_q   <= line_cnt_d;
				hdr_cnt_q    <= hdr_cnt_d;
				row_cnt_q    <= row_cnt_d;
				incons_q     <= incons_d;
			end
		end
	end

	// Capture stage: final counts of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eos_s1 <= 1'b0;
		else if (in_fire && is_eos)
			eos_s1 <= 1'b1;
		else if (advance)
			eos_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_eos) begin
			if (phase_q != PH_DONE) begin
				phase_s1 <= fin_phase;
				hdr_s1   <= fin_hdr;
				row_s1   <= fin_row;
				inc_s1   <= fin_inc;
			end else begin
				phase_s1 <= phase_q;
				hdr_s1   <= hdr_cnt_q;
				row_s1   <= row_cnt_q;
				inc_s1   <= incons_q;
			end
		end
	end

	fsd_decide #(
		.NUM_SEPARATORS (NUM_SEPARATORS),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) u_decide (
		.phase           (phase_s1),
		.hdr_cnt         (hdr_s1),
		.row_cnt         (row_s1),
		.incons          (inc_s1),
		.outcome         (dec_outcome),
		.header_sep_char (dec_hsep),
		.data_sep_char   (dec_dsep)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= eos_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && eos_s1) begin
			outcome_q <= dec_outcome;
			hsep_q    <= dec_hsep;
			dsep_q    <= dec_dsep;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.outcome         = outcome_q;
	assign result.header_sep_char = hsep_q;
	assign result.data_sep_char   = dsep_q;

	// Checks
	`FSD_ASSERT_NEXT(a_eos_clears, clk, arst_n, in_fire && is_eos,
		phase_q == PH_HEADER && !pending_cr_q && line_len_q == '0,
		"line state not cleared after end of stream")
	`FSD_ASSERT_NOW(a_done_empty_line, clk, arst_n, phase_q == PH_DONE,
		line_len_q == '0, "line length nonzero in done phase")
	`FSD_ASSERT_NEXT(a_capture_held, clk, arst_n, eos_s1 && !advance,
		eos_s1 && $stable(phase_s1), "captured end of stream lost under stall")
	`FSD_ASSERT_NOW(a_chars_only_found, clk, arst_n,
		out_valid_q && outcome_q != OUT_FOUND,
		hsep_q == 8'h00 && dsep_q == 8'h00, "separator given without a match")

endmodule

`default_nettype wire

/* src/fsd_decide.sv */
`default_nettype none

// Header-to-row separator matching over a snapshot of the counts
module fsd_decide import fsd_pkg::*; #(
	parameter int NUM_SEPARATORS = FSD_NUM_SEP,
	parameter int COUNT_WIDTH    = FSD_COUNT_W
) (
	input  phase_t                 phase,
	input  logic [COUNT_WIDTH-1:0] hdr_cnt [NUM_SEPARATORS],
	input  logic [COUNT_WIDTH-1:0] row_cnt [NUM_SEPARATORS],
	input  logic                   incons  [NUM_SEPARATORS],
	output outcome_t               outcome,
	output logic [7:0]             header_sep_char,
	output logic [7:0]             data_sep_char
);

	localparam int SEP_IDX_W = (NUM_SEPARATORS > 1) ? $clog2(NUM_SEPARATORS) : 1;

	logic                 any_match;
	logic                 multi_match;
	logic                 any_nonzero;
	logic [SEP_IDX_W-1:0] hi;
	logic [SEP_IDX_W-1:0] di;

	// Pair scan: last match wins, note whether more than one pair matched
	always_comb begin
		logic m;
		any_match   = 1'b0;
		multi_match = 1'b0;
		any_nonzero = 1'b0;
		hi          = '0;
		di          = '0;
		for (int h = 0; h < NUM_SEPARATORS; h++) begin
			for (int d = 0; d < NUM_SEPARATORS; d++) begin
				if (phase == PH_CHECK || phase == PH_DONE)
					m = (hdr_cnt[h] != '0) && !incons[d] && (hdr_cnt[h] == row_cnt[d]);
				else
					m = (hdr_cnt[h] != '0) && (h == d);
				if (m) begin
					multi_match = multi_match | any_match;
					any_match   = 1'b1;
					hi          = SEP_IDX_W'(h);
					di          = SEP_IDX_W'(d);
				end
			end
			if (hdr_cnt[h] != '0 || row_cnt[h] != '0 || incons[h])
				any_nonzero = 1'b1;
		end
	end

	// Result
	always_comb begin
		header_sep_char = 8'h00;
		data_sep_char   = 8'h00;
		if (phase == PH_HEADER) begin
			outcome = OUT_NO_LINE;
		end else if (any_match && !multi_match) begin
			outcome         = OUT_FOUND;
			header_sep_char = fsd_sep_char(3'(hi));
			data_sep_char   = fsd_sep_char(3'(di));
		end else if (multi_match || any_nonzero) begin
			outcome = OUT_AMBIG;
		end else begin
			outcome = OUT_NO_SEP;
		end
	end

endmodule

`default_nettype wire
